// ----- design/vfct_pkg.sv -----
// Shared types and constants of the view frustum cull test unit.
// No dependencies; imported by vfct_plane_unit and the top level.
package vfct_pkg;

  // Beat widths of the stream ports
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 8;

  // Configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int PLANE_W     = 64;

  // Plane packing and fixed-point format
  localparam int NORM_W  = 16;   // normal components, Q1.14
  localparam int OFFS_W  = 16;   // plane offset, world units
  localparam int Q_FRAC  = 14;   // fraction bits of the normals
  localparam int RAD_W   = 15;   // test radius in world units
  localparam int CORNERS = 8;    // corners of an axis-aligned box

  // Input field layout within in_tdata
  localparam int CMD_LSB  = 0;
  localparam int XLO_LSB  = 2;
  localparam int YLO_LSB  = 18;
  localparam int ZLO_LSB  = 34;
  localparam int XHI_LSB  = 50;
  localparam int YHI_LSB  = 66;
  localparam int ZHI_LSB  = 82;
  localparam int RAD_LSB  = 98;

  // Query kinds
  typedef enum logic [1:0] {
    CMD_POINT  = 2'd0,
    CMD_SPHERE = 2'd1,
    CMD_BOX    = 2'd2
  } cmd_t;

endpackage

// ----- design/vfct_plane_unit.sv -----
// One frustum plane: registered products of the normal with the query
// coordinates, then the exact side test for all eight box corners.
// Depends on vfct_pkg.
module vfct_plane_unit
  import vfct_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          load_en,
  input  logic [PLANE_W-1:0]            plane,
  input  logic signed [COORD_WIDTH-1:0] x_lo,
  input  logic signed [COORD_WIDTH-1:0] y_lo,
  input  logic signed [COORD_WIDTH-1:0] z_lo,
  input  logic signed [COORD_WIDTH-1:0] x_hi,
  input  logic signed [COORD_WIDTH-1:0] y_hi,
  input  logic signed [COORD_WIDTH-1:0] z_hi,
  input  logic [RAD_W-1:0]              radius,
  output logic [CORNERS-1:0]            pass
);

  localparam int PROD_W = NORM_W + COORD_WIDTH;
  localparam int OFFS_SCALED_W = OFFS_W + Q_FRAC;
  localparam int SUM_W = ((PROD_W > OFFS_SCALED_W) ? PROD_W : OFFS_SCALED_W) + 2;

  logic signed [NORM_W-1:0] nx, ny, nz;
  logic signed [PROD_W-1:0] px_lo_r, px_hi_r, py_lo_r, py_hi_r, pz_lo_r, pz_hi_r;
  logic signed [OFFS_W-1:0] offs_r;
  logic signed [SUM_W-1:0]  offs_scaled;
  logic signed [SUM_W-1:0]  rad_scaled;

  assign nx = plane[0*NORM_W +: NORM_W];
  assign ny = plane[1*NORM_W +: NORM_W];
  assign nz = plane[2*NORM_W +: NORM_W];

  // Form the six products once per beat; corners only pick among them
  always_ff @(posedge clk) begin
    if (load_en) begin
      px_lo_r <= nx * x_lo;
      px_hi_r <= nx * x_hi;
      py_lo_r <= ny * y_lo;
      py_hi_r <= ny * y_hi;
      pz_lo_r <= nz * z_lo;
      pz_hi_r <= nz * z_hi;
      offs_r  <= plane[3*NORM_W +: OFFS_W];
    end
  end

  // Both sides carry the 2^14 scale of the normals, so the test is exact
  assign offs_scaled = SUM_W'(offs_r) <<< Q_FRAC;
  assign rad_scaled  = $signed(SUM_W'({radius, {Q_FRAC{1'b0}}}));

  // Corner k takes the high coordinate on axis j when bit j of k is set
  always_comb begin
    logic signed [SUM_W-1:0] plane_dist;
    for (int k = 0; k < CORNERS; k++) begin
      plane_dist = SUM_W'(k[0] ? px_hi_r : px_lo_r)
                 + SUM_W'(k[1] ? py_hi_r : py_lo_r)
                 + SUM_W'(k[2] ? pz_hi_r : pz_lo_r)
                 + offs_scaled;
      pass[k] = (plane_dist <= rad_scaled);
    end
  end

endmodule

// ----- design/view_frustum_cull_test_unit.sv -----
// Top level of the view frustum cull test unit: stream ports, plane
// registers, query pipeline. Depends on vfct_pkg and vfct_plane_unit.
//
// Tests a point, sphere or axis-aligned box against up to six frustum
// planes and returns one beat with the visible flag per query. A query is
// accepted every cycle unless the output stalls with every stage full; its
// result passes the input register, product register and result register.
// Each plane has its own six 16 x 16 multipliers, so box corners share
// products and no unit is reused across cycles. Stages advance
// independently, so bubbles are squeezed out while the output is stalled.
// The user writes plane registers through the cfg port only while no
// query is in flight; the block does not enforce it. Reset clears them.
module view_frustum_cull_test_unit
  import vfct_pkg::*;
#(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [PLANE_W-1:0]     cfg_wdata,
  // queries
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata, low to high: cmd[1:0], x_low[17:2], y_low[33:18], z_low[49:34],
  // x_high[65:50], y_high[81:66], z_high[97:82], sphere_radius[112:98], zeros
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata, low to high: visible[0], zeros
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [PLANE_W-1:0] plane_r [PLANE_COUNT];

  logic                          s0_valid_r;
  cmd_t                          s0_cmd_r;
  logic signed [COORD_WIDTH-1:0] s0_xl_r, s0_yl_r, s0_zl_r;
  logic signed [COORD_WIDTH-1:0] s0_xh_r, s0_yh_r, s0_zh_r;
  logic [RAD_W-1:0]              s0_rad_r;

  logic                          s1_valid_r;
  cmd_t                          s1_cmd_r;
  logic [RAD_W-1:0]              s1_rad_r;
  logic [RAD_W-1:0]              s1_rad_nxt;

  logic                          out_valid_r;
  logic                          out_vis_r;
  logic                          out_vis_nxt;

  logic                          en0, en1, en2;
  logic [CORNERS-1:0]            plane_pass [PLANE_COUNT];
  logic [CORNERS-1:0]            corner_pass;

  // Per-stage advance: a stage loads when empty or when it drains
  assign en2       = !out_valid_r || out_tready;
  assign en1       = !s1_valid_r || en2;
  assign en0       = !s0_valid_r || en1;
  assign in_tready = en0;

  // Plane registers; indexes past the active planes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        plane_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        if (cfg_we && (cfg_index == CFG_INDEX_W'(i))) begin
          plane_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // Stage 0: capture the query beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en0) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_tvalid) begin
      s0_cmd_r <= cmd_t'(in_tdata[CMD_LSB +: 2]);
      s0_xl_r  <= in_tdata[XLO_LSB +: COORD_WIDTH];
      s0_yl_r  <= in_tdata[YLO_LSB +: COORD_WIDTH];
      s0_zl_r  <= in_tdata[ZLO_LSB +: COORD_WIDTH];
      s0_xh_r  <= in_tdata[XHI_LSB +: COORD_WIDTH];
      s0_yh_r  <= in_tdata[YHI_LSB +: COORD_WIDTH];
      s0_zh_r  <= in_tdata[ZHI_LSB +: COORD_WIDTH];
      s0_rad_r <= in_tdata[RAD_LSB +: RAD_W];
    end
  end

  // Test radius: zero for a point, the given radius for a sphere, half the largest box extent for a box
  always_comb begin
    logic signed [COORD_WIDTH:0] dx, dy, dz, ext;
    dx  = (COORD_WIDTH+1)'(s0_xh_r) - (COORD_WIDTH+1)'(s0_xl_r);
    dy  = (COORD_WIDTH+1)'(s0_yh_r) - (COORD_WIDTH+1)'(s0_yl_r);
    dz  = (COORD_WIDTH+1)'(s0_zh_r) - (COORD_WIDTH+1)'(s0_zl_r);
    ext = '0;
    if (dx > ext) ext = dx;
    if (dy > ext) ext = dy;
    if (dz > ext) ext = dz;
    case (s0_cmd_r)
      CMD_SPHERE: s1_rad_nxt = s0_rad_r;
      CMD_BOX:    s1_rad_nxt = RAD_W'(ext[COORD_WIDTH:1]);
      default:    s1_rad_nxt = '0;
    endcase
  end

  // Stage 1: products sit in the plane units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && s0_valid_r) begin
      s1_cmd_r <= s0_cmd_r;
      s1_rad_r <= s1_rad_nxt;
    end
  end

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    vfct_plane_unit #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_plane (
      .clk     (clk),
      .load_en (en1 && s0_valid_r),
      .plane   (plane_r[p]),
      .x_lo    (s0_xl_r),
      .y_lo    (s0_yl_r),
      .z_lo    (s0_zl_r),
      .x_hi    (s0_xh_r),
      .y_hi    (s0_yh_r),
      .z_hi    (s0_zh_r),
      .radius  (s1_rad_r),
      .pass    (plane_pass[p])
    );
  end

  // A corner survives only if no plane rejects it
  always_comb begin
    corner_pass = '1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      corner_pass = corner_pass & plane_pass[p];
    end
  end

  // Point and sphere use the low corner; a box needs any corner
  always_comb begin
    case (s1_cmd_r)
      CMD_POINT,
      CMD_SPHERE: out_vis_nxt = corner_pass[0];
      CMD_BOX:    out_vis_nxt = |corner_pass;
      default:    out_vis_nxt = 1'b0;
    endcase
  end

  // Stage 2: result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en2) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid_r) begin
      out_vis_r <= out_vis_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_vis_r};

`ifndef SYNTHESIS
  // Input stalls only when every stage holds a query
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s0_valid_r && s1_valid_r && out_valid_r))
    else $error("input stalled with a bubble in the pipeline");

  // A query leaving stage 1 must land in the result register
  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && en2) |=> out_tvalid)
    else $error("query lost between stage 1 and result");

  // An unused query kind is never reported visible
  a_unused_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && en2 && (s1_cmd_r != CMD_POINT) && (s1_cmd_r != CMD_SPHERE)
     && (s1_cmd_r != CMD_BOX)) |=> !out_tdata[0])
    else $error("unused query kind reported visible");
`endif

endmodule

// ----- tb/view_frustum_cull_test_unit_tb.sv -----
// Self-checking testbench of view_frustum_cull_test_unit: queries against
// several plane settings, checked beat by beat. Depends on vfct_pkg and the RTL.
`timescale 1ns / 1ps

module view_frustum_cull_test_unit_tb;
  import vfct_pkg::*;

  localparam int NUM_PLANES    = 6;
  localparam int COORD_W       = 16;
  localparam int PIPE_DEPTH    = 3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 66;
  localparam int MAX_REPORTS   = 10;
  localparam int Q_ONE         = 1 << Q_FRAC;

  // query kind with no meaning; the block answers not visible
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // plane settings of the random phases
  localparam int FR_TILT    = 0;
  localparam int FR_BOX     = 1;
  localparam int FR_RANDOM  = 2;
  localparam int FR_SPARSE  = 3;
  localparam int FR_NEG_EXT = 4;
  localparam int FR_POS_EXT = 5;
  localparam int FR_ONES    = 6;
  localparam int FR_STYLES  = 7;

  typedef struct {
    logic [1:0]          kind;
    logic signed [15:0]  xl, yl, zl, xh, yh, zh;
    logic [RAD_W-1:0]    radius;
  } query_t;

  // Plane copy, visibility predictor and queue of outstanding answers
  class visibility_checker;
    logic [PLANE_W-1:0] planes [NUM_PLANES];
    bit                 visible_due [$];
    int                 fail_count;
    int                 beat_count;

    function new();
      foreach (planes[i]) planes[i] = '0;
      fail_count = 0;
      beat_count = 0;
    endfunction

    function void set_plane(int idx, logic [PLANE_W-1:0] word);
      if (idx < NUM_PLANES) planes[idx] = word;
    endfunction

    // no plane puts the test point further out than r (scaled by 2^14)
    function bit passes_planes(longint x, longint y, longint z, longint r);
      longint nx, ny, nz, offs, plane_dist;
      for (int i = 0; i < NUM_PLANES; i++) begin
        nx   = $signed(planes[i][15:0]);
        ny   = $signed(planes[i][31:16]);
        nz   = $signed(planes[i][47:32]);
        offs = $signed(planes[i][63:48]);
        plane_dist = nx * x + ny * y + nz * z + offs * Q_ONE;
        if (plane_dist > r * Q_ONE) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit predict_visible(query_t q);
      longint xl, yl, zl, xh, yh, zh, span, half;
      bit seen;
      xl = q.xl; yl = q.yl; zl = q.zl;
      xh = q.xh; yh = q.yh; zh = q.zh;
      seen = 1'b0;
      case (q.kind)
        CMD_POINT:  seen = passes_planes(xl, yl, zl, 0);
        CMD_SPHERE: seen = passes_planes(xl, yl, zl, longint'(q.radius));
        CMD_BOX: begin
          // negative extents count as zero; corners keep the given bounds
          span = 0;
          if (xh - xl > span) span = xh - xl;
          if (yh - yl > span) span = yh - yl;
          if (zh - zl > span) span = zh - zl;
          half = span / 2;
          for (int k = 0; k < CORNERS; k++) begin
            if (passes_planes(k[0] ? xh : xl, k[1] ? yh : yl, k[2] ? zh : zl, half))
              seen = 1'b1;
          end
        end
        default: seen = 1'b0;
      endcase
      return seen;
    endfunction

    function void note_query(query_t q);
      visible_due.push_back(predict_visible(q));
    endfunction

    function void check_beat(logic got);
      bit want;
      beat_count++;
      if (visible_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("result beat %0d with no query outstanding: visible=%b", beat_count, got);
        return;
      end
      want = visible_due.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("result beat %0d: visible expected %b, got %b", beat_count, want, got);
      end
    endfunction

    function int pending();
      return visible_due.size();
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [PLANE_W-1:0]     cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // in_tdata, low to high: cmd, x_low, y_low, z_low, x_high, y_high, z_high,
  // sphere_radius, zeros
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_tdata, low to high: visible, zeros
  logic [OUT_TDATA_W-1:0] out_tdata;

  visibility_checker board = new();
  query_t             plan [$];
  logic [PLANE_W-1:0] frustum_next [NUM_PLANES];
  int                 ready_hold  = 0;
  int                 cycle_count = 0;

  view_frustum_cull_test_unit #(
    .PLANE_COUNT(NUM_PLANES),
    .COORD_WIDTH(COORD_W)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Toggle the result side between ready runs and stalls
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      ready_hold <= ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(8, 40);
    end else begin
      out_tready <= 1'b1;
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
    end
  end

  // Check every result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_beat(out_tdata[0]);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_query(query_t q);
    logic [IN_TDATA_W-1:0] w;
    w = '0;
    w[CMD_LSB +: 2]     = q.kind;
    w[XLO_LSB +: 16]    = q.xl;
    w[YLO_LSB +: 16]    = q.yl;
    w[ZLO_LSB +: 16]    = q.zl;
    w[XHI_LSB +: 16]    = q.xh;
    w[YHI_LSB +: 16]    = q.yh;
    w[ZHI_LSB +: 16]    = q.zh;
    w[RAD_LSB +: RAD_W] = q.radius;
    return w;
  endfunction

  function automatic query_t mk_query(logic [1:0] kind, int xl, int yl, int zl,
                                     int xh, int yh, int zh, int radius);
    query_t q;
    q.kind = kind;
    q.xl = 16'(xl); q.yl = 16'(yl); q.zl = 16'(zl);
    q.xh = 16'(xh); q.yh = 16'(yh); q.zh = 16'(zh);
    q.radius = RAD_W'(radius);
    return q;
  endfunction

  function automatic logic [PLANE_W-1:0] plane_word(int nx, int ny, int nz, int offs);
    return {16'(offs), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  // axis-aligned frustum around a centre; each plane rejects beyond one face
  function automatic void set_box_frustum(int cx, int cy, int cz, int hx, int hy, int hz);
    frustum_next[0] = plane_word(Q_ONE, 0, 0, -(cx + hx));
    frustum_next[1] = plane_word(-Q_ONE, 0, 0, cx - hx);
    frustum_next[2] = plane_word(0, Q_ONE, 0, -(cy + hy));
    frustum_next[3] = plane_word(0, -Q_ONE, 0, cy - hy);
    frustum_next[4] = plane_word(0, 0, Q_ONE, -(cz + hz));
    frustum_next[5] = plane_word(0, 0, -Q_ONE, cz - hz);
  endfunction

  function automatic int rand_norm();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic int rand_centre();
    return int'($urandom_range(0, 6000)) - 3000;
  endfunction

  function automatic void build_frustum(int style);
    case (style)
      FR_TILT: begin
        for (int i = 0; i < NUM_PLANES; i++)
          frustum_next[i] = plane_word(rand_norm(), rand_norm(), rand_norm(),
                                       int'($urandom_range(0, 16000)) - 12000);
      end
      FR_BOX:
        set_box_frustum(rand_centre(), rand_centre(), rand_centre(),
                        $urandom_range(0, 8000), $urandom_range(0, 8000),
                        $urandom_range(0, 8000));
      FR_RANDOM: begin
        for (int i = 0; i < NUM_PLANES; i++) frustum_next[i] = {$urandom, $urandom};
      end
      FR_SPARSE: begin
        set_box_frustum(rand_centre(), rand_centre(), rand_centre(),
                        $urandom_range(0, 8000), $urandom_range(0, 8000),
                        $urandom_range(0, 8000));
        for (int i = NUM_PLANES / 2; i < NUM_PLANES; i++) frustum_next[i] = '0;
      end
      FR_NEG_EXT: begin
        foreach (frustum_next[i]) frustum_next[i] = 64'h8000_8000_8000_8000;
      end
      FR_POS_EXT: begin
        foreach (frustum_next[i]) frustum_next[i] = 64'h7FFF_7FFF_7FFF_7FFF;
      end
      default: begin
        foreach (frustum_next[i]) frustum_next[i] = '1;
      end
    endcase
  endfunction

  function automatic logic signed [15:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 16'(int'($urandom_range(0, 12000)) - 6000);
    if (pick < 9) return 16'($urandom);
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return -16'sd1;
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] rand_radius();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return RAD_W'($urandom_range(0, 2000));
    if (pick < 8) return RAD_W'($urandom);
    return RAD_W'($urandom_range(0, 50));
  endfunction

  // box bound above a minimum, held inside the coordinate range
  function automatic logic signed [15:0] lift(logic signed [15:0] base, int span);
    int v;
    v = int'(base) + span;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  function automatic query_t rand_query();
    query_t q;
    q.kind = ($urandom_range(0, 19) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
    q.xl = rand_coord(); q.yl = rand_coord(); q.zl = rand_coord();
    q.xh = rand_coord(); q.yh = rand_coord(); q.zh = rand_coord();
    q.radius = rand_radius();
    // most boxes well formed, the rest inverted or arbitrary
    if (q.kind == CMD_BOX && $urandom_range(0, 9) < 8) begin
      q.xh = lift(q.xl, $urandom_range(0, 3000));
      q.yh = lift(q.yl, $urandom_range(0, 3000));
      q.zh = lift(q.zl, $urandom_range(0, 3000));
    end
    return q;
  endfunction

  // Offer one query, hold it until accepted, then idle for the given gap
  task automatic push_query(query_t q, int gap);
    in_tvalid <= 1'b1;
    in_tdata  <= pack_query(q);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_query(q);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send the planned queries; optionally hold off mid-way until all answered
  task automatic run_plan(bit pause_mid);
    int gap;
    bit no_gaps;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < plan.size(); i++) begin
      gap = no_gaps ? 0 : idle_gap();
      if ((i == plan.size() - 1 || (pause_mid && i == plan.size() / 2)) && gap == 0) gap = 1;
      push_query(plan[i], gap);
      if (pause_mid && i == plan.size() / 2)
        while (board.pending() != 0) @(posedge clk);
    end
    plan.delete();
  endtask

  // Wait until every answer is in and the pipeline has emptied
  task automatic settle();
    while (board.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Write all six planes plus one write to an index that holds no plane
  task automatic load_frustum(int stray_index);
    for (int i = 0; i < NUM_PLANES; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_INDEX_W'(i);
      cfg_wdata <= frustum_next[i];
      @(posedge clk);
      board.set_plane(i, frustum_next[i]);
    end
    cfg_index <= CFG_INDEX_W'(stray_index);
    cfg_wdata <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // planes cleared by reset: everything visible but the unused kind
    plan.push_back(mk_query(CMD_POINT, 32767, 32767, 32767, 0, 0, 0, 0));
    plan.push_back(mk_query(CMD_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767));
    plan.push_back(mk_query(CMD_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
    plan.push_back(mk_query(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0));
    run_plan(1'b0);
    settle();

    // cube of half size 1000 about the origin: touching and just-outside cases
    set_box_frustum(0, 0, 0, 1000, 1000, 1000);
    load_frustum((1 << CFG_INDEX_W) - 1);
    plan.push_back(mk_query(CMD_POINT, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk_query(CMD_POINT, 1000, -1000, 1000, 0, 0, 0, 0));
    plan.push_back(mk_query(CMD_POINT, 1001, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk_query(CMD_POINT, 0, 0, -1001, 0, 0, 0, 0));
    plan.push_back(mk_query(CMD_POINT, 1001, 0, 0, 0, 0, 0, 32767));
    plan.push_back(mk_query(CMD_SPHERE, 1100, 0, 0, 0, 0, 0, 100));
    plan.push_back(mk_query(CMD_SPHERE, 1100, 0, 0, 0, 0, 0, 99));
    plan.push_back(mk_query(CMD_SPHERE, 0, 0, 0, -32768, -32768, -32768, 0));
    plan.push_back(mk_query(CMD_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767));
    plan.push_back(mk_query(CMD_SPHERE, -32768, -32768, -32768, 0, 0, 0, 0));
    plan.push_back(mk_query(CMD_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
    plan.push_back(mk_query(CMD_BOX, 2000, 2000, 2000, 3000, 3000, 3000, 0));
    plan.push_back(mk_query(CMD_BOX, 1500, 0, 0, 2000, 0, 0, 0));
    plan.push_back(mk_query(CMD_BOX, 1200, 0, 0, 1600, 0, 0, 0));
    plan.push_back(mk_query(CMD_BOX, 500, 500, 500, -500, -500, -500, 0));
    plan.push_back(mk_query(CMD_BOX, 5000, 5000, 5000, 3000, 3000, 3000, 0));
    plan.push_back(mk_query(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0));
    run_plan(1'b0);
    settle();

    // random phases, each on its own plane setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      build_frustum(p % FR_STYLES);
      load_frustum(NUM_PLANES + $urandom_range(0, (1 << CFG_INDEX_W) - 1 - NUM_PLANES));
      repeat (PHASE_ITEMS) plan.push_back(rand_query());
      run_plan(p == 1);
      settle();
    end

    if (board.fail_count == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
